@@ src/caf_pkg.sv @@
// Shared constants, lane control/result types and saturation helper for the
// cartesian admittance filter. No dependencies.
`timescale 1ns / 1ps

package caf_pkg;

    localparam int AXES       = 3;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int DT_W       = 24;
    localparam int NF_W       = DATA_W + 1;
    localparam int WIDE_W     = 64;

    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 44;
    localparam int PROD_W     = 61;
    localparam int SUM_W      = 51;
    localparam int NET_W      = 44;

    localparam int ROT_SHIFT  = 14;
    localparam int GAIN_SHIFT = 8;
    localparam int DT_SHIFT   = 24;

    localparam int IN_TDATA_W  = 3 * AXES * DATA_W;
    localparam int OUT_TDATA_W = 2 * AXES * DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd6;

    localparam logic [COEF_W-1:0] ROT_ONE         = 16'h4000;
    localparam logic [DT_W-1:0]   TIME_STEP_RESET = 24'd16777;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_ROT0,
        STEP_ROT1,
        STEP_ROT2,
        STEP_SPRING,
        STEP_DAMP,
        STEP_NET,
        STEP_ACC,
        STEP_ACC_SAT,
        STEP_VEL,
        STEP_VEL_SAT,
        STEP_POS,
        STEP_POS_SAT,
        STEP_CLEAR
    } step_t;

    typedef struct packed {
        step_t                        step;
        logic [AXES-1:0][COEF_W-1:0]  rot_row;
        logic [COEF_W-1:0]            inv_mass;
        logic [COEF_W-1:0]            damping;
        logic [COEF_W-1:0]            stiffness;
        logic [DT_W-1:0]              time_step;
        logic [AXES-1:0][NF_W-1:0]    neg_force;
        logic [DATA_W-1:0]            target_force;
        logic [DATA_W-1:0]            target_offset;
    } lane_ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] velocity;
    } lane_res_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] a);
        logic signed [DATA_W-1:0] r;
        if (a > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end
        else if (a < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end
        else begin
            r = a[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/caf_lane.sv @@
// One axis of the admittance law: rotation row, mass-spring-damper and Euler
// integration, sequenced on a single multiplier. Depends on caf_pkg.
`timescale 1ns / 1ps

module caf_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  caf_pkg::lane_ctrl_t ctrl,
    output caf_pkg::lane_res_t  res
);
    import caf_pkg::*;

    logic signed [DATA_W-1:0]          offset_reg;
    logic signed [DATA_W-1:0]          velocity_reg;
    logic signed [DATA_W-1:0]          acc_reg;
    logic signed [NF_W-1:0]            diff_reg;
    logic signed [NF_W-1:0]            diff_next;
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [NET_W-1:0]           net_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [PROD_W-1:0]          prod_next;
    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic signed [SUM_W-1:0]           rot_scaled;
    logic signed [PROD_W-1:0]          prod_gain;
    logic signed [PROD_W-1:0]          prod_dt;
    logic signed [NET_W-1:0]           force_err;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.step)
            STEP_ROT0:
            begin
                mul_a = MUL_A_W'($signed(ctrl.rot_row[0]));
                mul_b = MUL_B_W'($signed(ctrl.neg_force[0]));
            end
            STEP_ROT1:
            begin
                mul_a = MUL_A_W'($signed(ctrl.rot_row[1]));
                mul_b = MUL_B_W'($signed(ctrl.neg_force[1]));
            end
            STEP_ROT2:
            begin
                mul_a = MUL_A_W'($signed(ctrl.rot_row[2]));
                mul_b = MUL_B_W'($signed(ctrl.neg_force[2]));
            end
            STEP_SPRING:
            begin
                mul_a = MUL_A_W'(ctrl.stiffness);
                mul_b = MUL_B_W'(diff_reg);
            end
            STEP_DAMP:
            begin
                mul_a = MUL_A_W'(ctrl.damping);
                mul_b = MUL_B_W'(velocity_reg);
            end
            STEP_ACC:
            begin
                mul_a = MUL_A_W'(ctrl.inv_mass);
                mul_b = net_reg;
            end
            STEP_VEL:
            begin
                mul_a = MUL_A_W'(ctrl.time_step);
                mul_b = MUL_B_W'(acc_reg);
            end
            STEP_POS:
            begin
                mul_a = MUL_A_W'(ctrl.time_step);
                mul_b = MUL_B_W'(velocity_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full   = mul_a * mul_b;
    assign prod_next  = mul_full[PROD_W-1:0];
    assign rot_scaled = sum_reg >>> ROT_SHIFT;
    assign prod_gain  = prod_reg >>> GAIN_SHIFT;
    assign prod_dt    = prod_reg >>> DT_SHIFT;
    assign force_err  = NET_W'($signed(ctrl.target_force)) - NET_W'(rot_scaled);
    assign diff_next  = NF_W'(offset_reg) - NF_W'($signed(ctrl.target_offset));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (ctrl.step)
            STEP_ROT0:    diff_reg <= diff_next;
            STEP_ROT1:    sum_reg  <= prod_reg[SUM_W-1:0];
            STEP_ROT2:    sum_reg  <= sum_reg + prod_reg[SUM_W-1:0];
            STEP_SPRING:  sum_reg  <= sum_reg + prod_reg[SUM_W-1:0];
            STEP_DAMP:    net_reg  <= force_err - prod_gain[NET_W-1:0];
            STEP_NET:     net_reg  <= net_reg - prod_gain[NET_W-1:0];
            STEP_ACC_SAT: acc_reg  <= sat_data(WIDE_W'(prod_gain));
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            velocity_reg <= '0;
        end
        else
        begin
            case (ctrl.step)
                STEP_CLEAR:
                begin
                    offset_reg   <= '0;
                    velocity_reg <= '0;
                end
                STEP_VEL_SAT:
                    velocity_reg <= sat_data(WIDE_W'(velocity_reg) + WIDE_W'(prod_dt));
                STEP_POS_SAT:
                    offset_reg <= sat_data(WIDE_W'(offset_reg) + WIDE_W'(prod_dt));
                default:
                begin
                end
            endcase
        end
    end

    assign res.offset   = offset_reg;
    assign res.velocity = velocity_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step == STEP_CLEAR |=> (offset_reg == '0 && velocity_reg == '0))
        else $error("lane state not cleared");

    a_velocity_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step != STEP_VEL_SAT && ctrl.step != STEP_CLEAR) |=> $stable(velocity_reg))
        else $error("velocity changed outside its update");

    a_zero_dt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctrl.step) == STEP_POS && $past(ctrl.time_step) == '0 &&
         ctrl.step == STEP_POS_SAT) |=> $stable(offset_reg))
        else $error("offset moved with zero time step");

endmodule

@@ src/caf_merge.sv @@
// Merging stage: gathers the per-axis results into one output transaction
// and holds it until taken. Depends on caf_pkg.
`timescale 1ns / 1ps

module caf_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  caf_pkg::lane_res_t [caf_pkg::AXES-1:0] lane_res,
    input  logic                                  load,
    output logic                                  ready,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [caf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import caf_pkg::*;

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [OUT_TDATA_W-1:0] data_next;

    always_comb
    begin
        data_next = '0;
        for (int k = 0; k < AXES; k++)
        begin
            data_next[DATA_W*k +: DATA_W]          = lane_res[k].offset;
            data_next[DATA_W*(AXES+k) +: DATA_W]   = lane_res[k].velocity;
        end
    end

    assign ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

@@ src/cartesian_admittance_filter_core.sv @@
// Top level of the cartesian admittance filter: configuration registers,
// input capture, step sequencer, three axis lanes and the merging stage.
// Depends on caf_pkg, caf_lane and caf_merge.
//
//   channel   signals                         content
//   s_axis    tvalid tready tdata tuser        force/offset sample, command
//   m_axis    tvalid tready tdata              new offset and velocity
//   cfg       cfg_valid cfg_ready index data   register write
//
// An update runs twelve sequence steps once its input is accepted: eight
// multiplications per axis issued one per cycle on one multiplier per lane,
// with accumulate and saturation steps between, then a completion step; the
// next input is accepted only after that. A clear command runs the clear
// step only. Reset restores registers and zeroes state.
// A held result stalls only the completion step; cfg is always ready.
`timescale 1ns / 1ps

module cartesian_admittance_filter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // measured_force_x/y/z, target_force_x/y/z, target_offset_x/y/z
    input  logic [caf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // offset_x/y/z, velocity_x/y/z
    output logic [caf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [caf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [caf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import caf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    step_t                   step_reg;
    logic [CFG_DATA_W-1:0]   inv_mass_reg;
    logic [CFG_DATA_W-1:0]   damping_reg;
    logic [CFG_DATA_W-1:0]   stiffness_reg;
    logic [CFG_DATA_W-1:0]   row_reg [AXES];
    logic [DT_W-1:0]         time_step_reg;
    logic [NF_W-1:0]         neg_force_reg [AXES];
    logic [DATA_W-1:0]       target_force_reg [AXES];
    logic [DATA_W-1:0]       target_offset_reg [AXES];
    lane_ctrl_t              lane_ctrl [AXES];
    lane_res_t [AXES-1:0]    lane_res;
    logic                    out_ready;
    logic                    in_take;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg  <= '0;
            damping_reg   <= '0;
            stiffness_reg <= '0;
            for (int k = 0; k < AXES; k++)
            begin
                row_reg[k] <= CFG_DATA_W'(ROT_ONE) << (COEF_W * k);
            end
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INV_MASS:  inv_mass_reg  <= cfg_data;
                REG_DAMPING:   damping_reg   <= cfg_data;
                REG_STIFFNESS: stiffness_reg <= cfg_data;
                REG_ROT_ROW0:  row_reg[0]    <= cfg_data;
                REG_ROT_ROW1:  row_reg[1]    <= cfg_data;
                REG_ROT_ROW2:  row_reg[2]    <= cfg_data;
                REG_TIME_STEP: time_step_reg <= cfg_data[DT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                neg_force_reg[k]     <= NF_W'(0) -
                                        NF_W'($signed(s_axis_tdata[DATA_W*k +: DATA_W]));
                target_force_reg[k]  <= s_axis_tdata[DATA_W*(AXES+k) +: DATA_W];
                target_offset_reg[k] <= s_axis_tdata[DATA_W*(2*AXES+k) +: DATA_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= s_axis_tuser[0] ? STEP_CLEAR : STEP_ROT0;
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == STEP_POS_SAT || step_reg == STEP_CLEAR)
                    begin
                        state_reg <= ST_DONE;
                        step_reg  <= STEP_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_t'(step_reg + 1'b1);
                    end
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    step_reg  <= STEP_IDLE;
                end
            endcase
        end
    end

    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        always_comb
        begin
            lane_ctrl[k].step          = step_reg;
            lane_ctrl[k].rot_row       = (AXES*COEF_W)'(row_reg[k]);
            lane_ctrl[k].inv_mass      = inv_mass_reg[COEF_W*k +: COEF_W];
            lane_ctrl[k].damping       = damping_reg[COEF_W*k +: COEF_W];
            lane_ctrl[k].stiffness     = stiffness_reg[COEF_W*k +: COEF_W];
            lane_ctrl[k].time_step     = time_step_reg;
            for (int j = 0; j < AXES; j++)
            begin
                lane_ctrl[k].neg_force[j] = neg_force_reg[j];
            end
            lane_ctrl[k].target_force  = target_force_reg[k];
            lane_ctrl[k].target_offset = target_offset_reg[k];
        end

        caf_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl[k]),
            .res   (lane_res[k])
        );
    end

    caf_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_res      (lane_res),
        .load          (state_reg == ST_DONE),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_update_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !s_axis_tuser[0]) |=> (state_reg == ST_RUN && step_reg == STEP_ROT0))
        else $error("update transaction did not start the sequence");

    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && s_axis_tuser[0]) |=> (state_reg == ST_RUN && step_reg == STEP_CLEAR))
        else $error("clear transaction did not start a clear");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_ready) |=> (m_axis_tvalid && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule
